FILE: hdl/ebf_pkg.sv
// shared codes and widths for the edge list shortest path engine
// no dependencies; imported by ebf top level
`default_nettype none

package ebf_pkg;

   localparam int ACTION_BITS = 2;
   localparam int STATUS_BITS = 3;
   localparam int DIST_BITS   = 24;

   localparam logic [ACTION_BITS-1:0] ACT_ADD   = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_DEL   = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_SOLVE = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_RANGE     = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_EXISTS    = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd4;

   localparam logic [0:0] REG_DIRECTED = 1'd0;
   localparam logic [0:0] REG_VCOUNT   = 1'd1;

   localparam logic signed [DIST_BITS-1:0] DIST_MAX = 24'sh7FFFFF;
   localparam logic signed [DIST_BITS-1:0] DIST_MIN = 24'sh800000;

endpackage

`default_nettype wire

FILE: hdl/edge_list_bellman_ford_top.sv
// edge list bellman-ford engine: edit sequencer, relaxation loop, result emitter
// depends on ebf_pkg and ebf_ram
//
// channel   direction  handshake              payload
// req       in         start & !busy          action, from_vertex, to_vertex, edge_weight
// rsp       out        rsp_valid (one cycle)  status, vertex_index, reachable, distance,
//                                             predecessor, last
// csr       in         csr_valid & csr_ready  csr_index, csr_wdata
//
// delete and add scan the store with one edge memory read per entry; a directed add then
// writes one entry and an undirected add two
// solve clears the vertex table, runs n-1 passes over the store (none with an empty store),
// then emits one result per vertex: each entry costs an edge read then a vertex table read
// and write back; range errors and reserved actions answer next
// synchronous reset clears the edge count and control registers; payload registers and memories are not cleared
// busy drops at the edge that registers the last result; results cannot be stalled
`default_nettype none

module edge_list_bellman_ford_top #(
   parameter int MAX_VERTICES = 16,
   parameter int MAX_ENTRIES  = 64,
   parameter int WEIGHT_BITS  = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic [ebf_pkg::ACTION_BITS-1:0]         req_action,
   input  wire logic [$clog2(MAX_VERTICES)-1:0]         req_from_vertex,
   input  wire logic [$clog2(MAX_VERTICES)-1:0]         req_to_vertex,
   input  wire logic signed [WEIGHT_BITS-1:0]           req_edge_weight,
   output logic                                         rsp_valid,
   output logic [ebf_pkg::STATUS_BITS-1:0]              rsp_status,
   output logic [$clog2(MAX_VERTICES)-1:0]              rsp_vertex_index,
   output logic                                         rsp_reachable,
   output logic signed [ebf_pkg::DIST_BITS-1:0]         rsp_distance,
   output logic [$clog2(MAX_VERTICES)-1:0]              rsp_predecessor,
   output logic                                         rsp_last,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [0:0]                              csr_index,
   input  wire logic [$clog2(MAX_VERTICES+1)-1:0]       csr_wdata
);

   import ebf_pkg::*;

   localparam int VB  = $clog2(MAX_VERTICES);
   localparam int CW  = $clog2(MAX_VERTICES + 1);
   localparam int EAW = $clog2(MAX_ENTRIES);
   localparam int EIW = $clog2(MAX_ENTRIES + 1);
   localparam int VW  = VB + 1 + DIST_BITS;
   localparam int EW  = 2 * VB + WEIGHT_BITS;
   localparam int SW  = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_SCAN       = 4'd1;
   localparam logic [3:0] S_ADD_WR1    = 4'd2;
   localparam logic [3:0] S_ADD_WR2    = 4'd3;
   localparam logic [3:0] S_INIT       = 4'd4;
   localparam logic [3:0] S_PASS_START = 4'd5;
   localparam logic [3:0] S_RELAX_A    = 4'd6;
   localparam logic [3:0] S_RELAX_B    = 4'd7;
   localparam logic [3:0] S_EMIT_RD    = 4'd8;
   localparam logic [3:0] S_EMIT       = 4'd9;

   // control and configuration registers
   logic [3:0]             state_ff, state_in;
   logic                   directed_ff, directed_in;
   logic [CW-1:0]          vcount_ff, vcount_in;
   logic [EIW-1:0]         count_ff, count_in;
   logic [EIW-1:0]         rd_idx_ff, rd_idx_in;
   logic                   pv_ff, pv_in;
   logic [EIW-1:0]         keep_ff, keep_in;
   logic                   found_ff, found_in;
   logic [EIW-1:0]         e_idx_ff, e_idx_in;
   logic [CW-1:0]          pass_ff, pass_in;
   logic [CW-1:0]          v_idx_ff, v_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // item payload and relaxation operands
   logic [ACTION_BITS-1:0] act_ff, act_in;
   logic [VB-1:0]          a_ff, a_in;
   logic [VB-1:0]          b_ff, b_in;
   logic [WEIGHT_BITS-1:0] w_ff, w_in;
   logic [VB-1:0]          ra_ff, ra_in;
   logic [VB-1:0]          rb_ff, rb_in;
   logic [WEIGHT_BITS-1:0] rw_ff, rw_in;

   logic [STATUS_BITS-1:0]       rsp_status_ff, rsp_status_in;
   logic [VB-1:0]                rsp_vidx_ff, rsp_vidx_in;
   logic                         rsp_reach_ff, rsp_reach_in;
   logic signed [DIST_BITS-1:0]  rsp_dist_ff, rsp_dist_in;
   logic [VB-1:0]                rsp_pred_ff, rsp_pred_in;
   logic                         rsp_last_ff, rsp_last_in;

   // memory ports
   logic           e_we, e_re;
   logic [EAW-1:0] e_waddr, e_raddr;
   logic [EW-1:0]  e_wdata, e_rdata;
   logic           v_we, v0_re, v1_re;
   logic [VB-1:0]  v_waddr, v0_raddr, v1_raddr;
   logic [VW-1:0]  v_wdata, v0_rdata, v1_rdata;

   logic [CW-1:0]                n_cnt;
   logic [VB-1:0]                e_from, e_to;
   logic                         hit;
   logic                         full;
   logic signed [DIST_BITS-1:0]  dist_a, dist_b, cand;
   logic                         reach_a, reach_b, edge_ok, improve;
   logic signed [SW-1:0]         sum;

   ebf_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_edges (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr (e_waddr),
      .wr_data (e_wdata),
      .rd_en   (e_re),
      .rd_addr (e_raddr),
      .rd_data (e_rdata)
   );

   // two copies of the vertex table so source and target are read in the same cycle
   ebf_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vtx_src (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata),
      .rd_en   (v0_re),
      .rd_addr (v0_raddr),
      .rd_data (v0_rdata)
   );

   ebf_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vtx_dst (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata),
      .rd_en   (v1_re),
      .rd_addr (v1_raddr),
      .rd_data (v1_rdata)
   );

   always_comb begin
      if (vcount_ff == '0) begin
         n_cnt = CW'(1);
      end else if (vcount_ff > CW'(MAX_VERTICES)) begin
         n_cnt = CW'(MAX_VERTICES);
      end else begin
         n_cnt = vcount_ff;
      end
   end

   assign e_from = e_rdata[EW-1 -: VB];
   assign e_to   = e_rdata[EW-VB-1 -: VB];
   assign hit    = ((e_from == a_ff) && (e_to == b_ff)) ||
                   (!directed_ff && (e_from == b_ff) && (e_to == a_ff));
   assign full   = ((EIW+1)'(count_ff) + (directed_ff ? (EIW+1)'(1) : (EIW+1)'(2)))
                   > (EIW+1)'(MAX_ENTRIES);

   // relaxation datapath, vertex word is {predecessor, reached, distance}
   assign dist_a  = v0_rdata[DIST_BITS-1:0];
   assign reach_a = v0_rdata[DIST_BITS];
   assign dist_b  = v1_rdata[DIST_BITS-1:0];
   assign reach_b = v1_rdata[DIST_BITS];
   assign sum     = SW'(dist_a) + SW'($signed(rw_ff));
   always_comb begin
      if (sum > SW'(DIST_MAX)) begin
         cand = DIST_MAX;
      end else if (sum < SW'(DIST_MIN)) begin
         cand = DIST_MIN;
      end else begin
         cand = sum[DIST_BITS-1:0];
      end
   end
   assign edge_ok = (CW'(ra_ff) < n_cnt) && (CW'(rb_ff) < n_cnt) && reach_a;
   assign improve = edge_ok && (!reach_b || (cand < dist_b));

   always_comb begin
      state_in      = state_ff;
      directed_in   = directed_ff;
      vcount_in     = vcount_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      pv_in         = 1'b0;
      keep_in       = keep_ff;
      found_in      = found_ff;
      e_idx_in      = e_idx_ff;
      pass_in       = pass_ff;
      v_idx_in      = v_idx_ff;
      act_in        = act_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      w_in          = w_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      rw_in         = rw_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_vidx_in   = '0;
      rsp_reach_in  = 1'b0;
      rsp_dist_in   = '0;
      rsp_pred_in   = '0;
      rsp_last_in   = 1'b1;
      e_we          = 1'b0;
      e_waddr       = count_ff[EAW-1:0];
      e_wdata       = {a_ff, b_ff, w_ff};
      e_re          = 1'b0;
      e_raddr       = rd_idx_ff[EAW-1:0];
      v_we          = 1'b0;
      v_waddr       = v_idx_ff[VB-1:0];
      v_wdata       = '0;
      v0_re         = 1'b0;
      v0_raddr      = e_from;
      v1_re         = 1'b0;
      v1_raddr      = e_to;

      if (csr_valid) begin
         case (csr_index)
            REG_DIRECTED: directed_in = csr_wdata[0];
            REG_VCOUNT:   vcount_in   = csr_wdata;
            default:      ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in = req_action;
               a_in   = req_from_vertex;
               b_in   = req_to_vertex;
               w_in   = req_edge_weight;
               if (req_action == ACT_SOLVE) begin
                  if (CW'(req_from_vertex) >= n_cnt) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_RANGE;
                  end else begin
                     v_idx_in = '0;
                     state_in = S_INIT;
                  end
               end else if (req_action != ACT_ADD && req_action != ACT_DEL) begin
                  rsp_valid_in = 1'b1;
               end else if (CW'(req_from_vertex) >= n_cnt ||
                            CW'(req_to_vertex) >= n_cnt) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_RANGE;
               end else begin
                  rd_idx_in = '0;
                  keep_in   = '0;
                  found_in  = 1'b0;
                  state_in  = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // read one entry a cycle, check it the cycle after
            if (rd_idx_ff != count_ff) begin
               e_re      = 1'b1;
               rd_idx_in = rd_idx_ff + EIW'(1);
               pv_in     = 1'b1;
            end
            if (pv_ff) begin
               if (hit) begin
                  found_in = 1'b1;
               end else if (act_ff == ACT_DEL) begin
                  // compacting write lands at or below the entry just read
                  e_we    = 1'b1;
                  e_waddr = keep_ff[EAW-1:0];
                  e_wdata = e_rdata;
                  keep_in = keep_ff + EIW'(1);
               end
            end else if (rd_idx_ff == count_ff) begin
               if (act_ff == ACT_DEL) begin
                  count_in      = keep_ff;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = found_ff ? ST_OK : ST_NOT_FOUND;
                  state_in      = S_IDLE;
               end else if (found_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_EXISTS;
                  state_in      = S_IDLE;
               end else if (full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FULL;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_ADD_WR1;
               end
            end
         end

         S_ADD_WR1: begin
            e_we     = 1'b1;
            count_in = count_ff + EIW'(1);
            if (directed_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_ADD_WR2;
            end
         end

         S_ADD_WR2: begin
            e_we         = 1'b1;
            e_wdata      = {b_ff, a_ff, w_ff};
            count_in     = count_ff + EIW'(1);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         S_INIT: begin
            // clear the vertex table, only the source starts reached
            v_we     = 1'b1;
            v_wdata  = {VB'(0), (v_idx_ff[VB-1:0] == a_ff), DIST_BITS'(0)};
            v_idx_in = v_idx_ff + CW'(1);
            if (v_idx_ff == CW'(MAX_VERTICES - 1)) begin
               pass_in  = CW'(1);
               state_in = S_PASS_START;
            end
         end

         S_PASS_START: begin
            if (pass_ff < n_cnt && count_ff != '0) begin
               e_re     = 1'b1;
               e_raddr  = '0;
               e_idx_in = '0;
               state_in = S_RELAX_A;
            end else begin
               v_idx_in = '0;
               state_in = S_EMIT_RD;
            end
         end

         S_RELAX_A: begin
            ra_in = e_from;
            rb_in = e_to;
            rw_in = e_rdata[WEIGHT_BITS-1:0];
            v0_re = 1'b1;
            v1_re = 1'b1;
            if ((e_idx_ff + EIW'(1)) != count_ff) begin
               e_re    = 1'b1;
               e_raddr = EAW'(e_idx_ff + EIW'(1));
            end
            state_in = S_RELAX_B;
         end

         S_RELAX_B: begin
            // write back lands before the next entry reads the table
            if (improve) begin
               v_we    = 1'b1;
               v_waddr = rb_ff;
               v_wdata = {ra_ff, 1'b1, cand};
            end
            if ((e_idx_ff + EIW'(1)) == count_ff) begin
               pass_in  = pass_ff + CW'(1);
               state_in = S_PASS_START;
            end else begin
               e_idx_in = e_idx_ff + EIW'(1);
               state_in = S_RELAX_A;
            end
         end

         S_EMIT_RD: begin
            v0_re    = 1'b1;
            v0_raddr = '0;
            state_in = S_EMIT;
         end

         S_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_vidx_in  = v_idx_ff[VB-1:0];
            rsp_reach_in = v0_rdata[DIST_BITS];
            rsp_dist_in  = v0_rdata[DIST_BITS] ? v0_rdata[DIST_BITS-1:0] : '0;
            rsp_pred_in  = v0_rdata[DIST_BITS] ? v0_rdata[VW-1 -: VB] : '0;
            rsp_last_in  = (v_idx_ff == n_cnt - CW'(1));
            v_idx_in     = v_idx_ff + CW'(1);
            if (v_idx_ff == n_cnt - CW'(1)) begin
               state_in = S_IDLE;
            end else begin
               v0_re    = 1'b1;
               v0_raddr = VB'(v_idx_ff + CW'(1));
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         directed_ff  <= 1'b1;
         vcount_ff    <= CW'(MAX_VERTICES);
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         pv_ff        <= 1'b0;
         keep_ff      <= '0;
         found_ff     <= 1'b0;
         e_idx_ff     <= '0;
         pass_ff      <= '0;
         v_idx_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         directed_ff  <= directed_in;
         vcount_ff    <= vcount_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         pv_ff        <= pv_in;
         keep_ff      <= keep_in;
         found_ff     <= found_in;
         e_idx_ff     <= e_idx_in;
         pass_ff      <= pass_in;
         v_idx_ff     <= v_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      w_ff          <= w_in;
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      rw_ff         <= rw_in;
      rsp_status_ff <= rsp_status_in;
      rsp_vidx_ff   <= rsp_vidx_in;
      rsp_reach_ff  <= rsp_reach_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_pred_ff   <= rsp_pred_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_vertex_index = rsp_vidx_ff;
   assign rsp_reachable    = rsp_reach_ff;
   assign rsp_distance     = rsp_dist_ff;
   assign rsp_predecessor  = rsp_pred_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hdl/ebf_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies; used for the edge list and the vertex tables
`default_nettype none

module ebf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
